[design/fspp_pkg.sv]
// Package for the fair-share process picker: codes, constants, nice weight table.
// Used by the picker core; depends on nothing.
`timescale 1ns / 1ps
package fspp_pkg;
	localparam int DEF_SLOTS = 64;
	localparam int SLICE_SCALE = 10000;
	localparam int TICK_SCALE = 1024000;
	localparam int NICE_MAX = 39;
	localparam int NICE_RESET = 20;

	localparam logic [2:0] FN_PICK = 3'd0;
	localparam logic [2:0] FN_WAKE = 3'd1;
	localparam logic [2:0] FN_KILL = 3'd2;
	localparam logic [2:0] FN_SETN = 3'd3;
	localparam logic [2:0] FN_GETN = 3'd4;
	localparam logic [2:0] FN_LOAD = 3'd5;

	localparam logic [2:0] ST_SLEEPING = 3'd2;
	localparam logic [2:0] ST_RUNNABLE = 3'd3;
	localparam logic [2:0] ST_RUNNING = 3'd4;

	localparam logic [1:0] RS_OK = 2'd0;
	localparam logic [1:0] RS_NONE = 2'd1;
	localparam logic [1:0] RS_RANGE = 2'd2;

	// weight of a nice level, levels above the top clamp to the top
	function automatic logic [16:0] nice_weight(input logic [5:0] n);
		logic [16:0] w;
		case ((n > 6'd39) ? 6'd39 : n)
			6'd0: w = 17'd88761;  6'd1: w = 17'd71755;  6'd2: w = 17'd56483;
			6'd3: w = 17'd46273;  6'd4: w = 17'd36291;  6'd5: w = 17'd29154;
			6'd6: w = 17'd23254;  6'd7: w = 17'd18705;  6'd8: w = 17'd14949;
			6'd9: w = 17'd11916;  6'd10: w = 17'd9548;  6'd11: w = 17'd7620;
			6'd12: w = 17'd6100;  6'd13: w = 17'd4904;  6'd14: w = 17'd3906;
			6'd15: w = 17'd3121;  6'd16: w = 17'd2501;  6'd17: w = 17'd1991;
			6'd18: w = 17'd1586;  6'd19: w = 17'd1277;  6'd20: w = 17'd1024;
			6'd21: w = 17'd820;   6'd22: w = 17'd655;   6'd23: w = 17'd526;
			6'd24: w = 17'd423;   6'd25: w = 17'd335;   6'd26: w = 17'd272;
			6'd27: w = 17'd215;   6'd28: w = 17'd172;   6'd29: w = 17'd137;
			6'd30: w = 17'd110;   6'd31: w = 17'd87;    6'd32: w = 17'd70;
			6'd33: w = 17'd56;    6'd34: w = 17'd45;    6'd35: w = 17'd36;
			6'd36: w = 17'd29;    6'd37: w = 17'd23;    6'd38: w = 17'd18;
			default: w = 17'd15;
		endcase
		return w;
	endfunction
endpackage

[design/fspp_div.sv]
// Restoring divider, one quotient bit per cycle, shared by tick and slice math.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps
module fspp_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0] quo_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] dsr_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [W:0] trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dsr_q};
	assign quotient = quo_q;

	// shift-subtract step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				quo_q <= dividend;
				rem_q <= '0;
				dsr_q <= divisor;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				if (trial[W]) begin
					rem_q <= {rem_q[W-2:0], quo_q[W-1]};
					quo_q <= {quo_q[W-2:0], 1'b0};
				end else begin
					rem_q <= trial[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b1};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule

[design/fair_share_process_picker_core.sv]
// Fair-share process picker: one item at a time, slots scanned one per cycle.
// Steps: pick runs tick divide, min scan, apply scan and slice divide; wake and kill
// run tick divide, min scan and apply scan; nice ops run the apply scan; load writes directly.
// Throughput: one item in flight; the next input beat is taken at the edge the
// result beat leaves or later.
// Reset: asynchronous; a clearing pass over all slots then runs before the first item.
`timescale 1ns / 1ps
module fair_share_process_picker_core #(
	parameter int SLOTS = fspp_pkg::DEF_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [5:0]  slot,
	input  logic [15:0] task_id,
	input  logic [31:0] wait_channel,
	input  logic [5:0]  nice_value,
	input  logic [5:0]  running_nice,
	input  logic [2:0]  entry_status,
	input  logic [31:0] entry_vruntime,
	input  logic [31:0] entry_overflow,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [5:0]  chosen_slot,
	output logic [13:0] granted_slice,
	output logic [6:0]  woken_count,
	output logic [5:0]  nice_read
);
	import fspp_pkg::*;
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_TDIV, S_MRD, S_MIN, S_ARD, S_APPLY, S_SDIV, S_OUT
	} state_t;
	state_t state_q;

	// slot table memories
	logic [2:0]  m_status [SLOTS];
	logic [5:0]  m_nice   [SLOTS];
	logic [31:0] m_vrun   [SLOTS];
	logic [31:0] m_wraps  [SLOTS];
	logic [31:0] m_chan   [SLOTS];
	logic [15:0] m_id     [SLOTS];
	logic        m_killed [SLOTS];

	logic [AW-1:0] ra;
	logic [2:0] r_status;
	logic [5:0] r_nice;
	logic [31:0] r_vrun, r_wraps, r_chan;
	logic [15:0] r_id;
	logic        we;
	logic        we_nice;
	logic        we_killed;
	logic [AW-1:0] wa;
	logic [2:0] w_status;
	logic [5:0] w_nice;
	logic [31:0] w_vrun, w_wraps, w_chan;
	logic [15:0] w_id;
	logic        w_killed;

	// nice and killed have their own enables so other writes keep them
	always_ff @(posedge clk) begin
		r_status <= m_status[ra];
		r_nice <= m_nice[ra];
		r_vrun <= m_vrun[ra];
		r_wraps <= m_wraps[ra];
		r_chan <= m_chan[ra];
		r_id <= m_id[ra];
		if (we) begin
			m_status[wa] <= w_status;
			m_vrun[wa] <= w_vrun;
			m_wraps[wa] <= w_wraps;
			m_chan[wa] <= w_chan;
			m_id[wa] <= w_id;
		end
		if (we_nice) m_nice[wa] <= w_nice;
		if (we_killed) m_killed[wa] <= w_killed;
	end

	// captured item
	logic [2:0]  func_q;
	logic [5:0]  nval_q;
	logic [15:0] id_q;
	logic [31:0] chan_q;
	logic [CW-1:0] idx_q;
	logic        rd_ok_q;
	logic [AW-1:0] rd_idx_q;
	logic        min_ok_q, min_stop_q;
	logic [AW-1:0] min_idx_q;
	logic [31:0] min_v_q, min_w_q;
	logic [31:0] tick_q;
	logic [24:0] total_q;
	logic [16:0] min_wt_q;
	logic        found_q;
	logic [1:0]  status_q;
	logic [5:0]  chosen_q, nread_q;
	logic [13:0] slice_q;
	logic [6:0]  woken_q;
	logic        out_q;

	// shared divider
	logic dv_start, dv_done;
	logic [31:0] dv_a, dv_b, dv_q;
	fspp_div #(.W(32)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(dv_a),
		.divisor(dv_b), .done(dv_done), .quotient(dv_q)
	);

	// placement below current minimum
	logic [31:0] pl_v, pl_w;
	always_comb begin
		pl_v = 32'd0;
		pl_w = 32'd0;
		if (min_ok_q) begin
			if (min_v_q >= tick_q) begin
				pl_w = min_w_q;
				pl_v = min_v_q - tick_q;
			end else if (min_w_q != 32'd0) begin
				pl_w = min_w_q - 32'd1;
				pl_v = 32'hFFFFFFFF - tick_q + min_v_q;
			end
		end
	end

	logic last_idx;
	assign last_idx = (idx_q == CW'(SLOTS));
	logic [39:0] slice_num;
	assign slice_num = 40'(SLICE_SCALE) * 40'(min_wt_q);

	// a waiting result beat holds off the next input beat
	logic take;
	assign in_stall = (state_q != S_IDLE) || (out_q && out_stall);
	assign take = in_valid && !in_stall;
	assign out_valid = out_q;
	assign status = status_q;
	assign chosen_slot = chosen_q;
	assign granted_slice = slice_q;
	assign woken_count = woken_q;
	assign nice_read = nread_q;

	// memory port and divider drive
	always_comb begin
		ra = idx_q[AW-1:0];
		we = 1'b0;
		we_nice = 1'b0;
		we_killed = 1'b0;
		wa = rd_idx_q;
		w_status = r_status;
		w_nice = r_nice;
		w_vrun = r_vrun;
		w_wraps = r_wraps;
		w_chan = r_chan;
		w_id = r_id;
		w_killed = 1'b0;
		dv_start = 1'b0;
		dv_a = 32'(TICK_SCALE);
		dv_b = 32'(nice_weight(running_nice));
		if (state_q == S_CLEAR) begin
			we = 1'b1;
			we_nice = 1'b1;
			we_killed = 1'b1;
			wa = idx_q[AW-1:0];
			w_status = 3'd0;
			w_nice = 6'(NICE_RESET);
			w_vrun = '0;
			w_wraps = '0;
			w_chan = '0;
			w_id = '0;
		end else if (take && func == FN_LOAD) begin
			we = (32'(slot) < 32'(SLOTS));
			we_killed = we;
			wa = AW'(slot);
			w_status = entry_status;
			w_vrun = entry_vruntime;
			w_wraps = entry_overflow;
			w_chan = wait_channel;
			w_id = task_id;
		end else if (take) begin
			dv_start = 1'b1;
		end else if (state_q == S_APPLY && rd_ok_q && !found_q) begin
			case (func_q)
				FN_PICK: if (rd_idx_q == min_idx_q) begin
					we = 1'b1;
					w_status = ST_RUNNING;
				end
				FN_WAKE: if (r_status == ST_SLEEPING && r_chan == chan_q) begin
					we = 1'b1;
					w_status = ST_RUNNABLE;
					w_vrun = pl_v;
					w_wraps = pl_w;
				end
				FN_KILL: if (r_id == id_q) begin
					we = 1'b1;
					we_killed = 1'b1;
					w_killed = 1'b1;
					if (r_status == ST_SLEEPING) begin
						w_status = ST_RUNNABLE;
						w_vrun = pl_v;
						w_wraps = pl_w;
					end
				end
				FN_SETN: if (r_id == id_q) begin
					we_nice = 1'b1;
					w_nice = nval_q;
				end
				default: ;
			endcase
		end else if (state_q == S_APPLY && !rd_ok_q && func_q == FN_PICK) begin
			dv_start = 1'b1;
			dv_a = slice_num[31:0];
			dv_b = 32'(total_q);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			idx_q <= '0;
			out_q <= 1'b0;
			rd_ok_q <= 1'b0;
		end else begin
			rd_ok_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == CW'(SLOTS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (out_q && !out_stall) out_q <= 1'b0;
					if (take) begin
						func_q <= func;
						id_q <= task_id;
						chan_q <= wait_channel;
						nval_q <= nice_value;
						status_q <= RS_OK;
						chosen_q <= '0;
						slice_q <= '0;
						woken_q <= '0;
						nread_q <= '0;
						idx_q <= '0;
						min_ok_q <= 1'b0;
						min_stop_q <= 1'b0;
						found_q <= 1'b0;
						total_q <= '0;
						case (func)
							FN_LOAD: begin
								if (32'(slot) < 32'(SLOTS)) chosen_q <= slot;
								else status_q <= RS_NONE;
								state_q <= S_OUT;
							end
							FN_SETN: begin
								if (nice_value > 6'(NICE_MAX)) begin
									status_q <= RS_RANGE;
									state_q <= S_OUT;
								end else state_q <= S_ARD;
							end
							FN_GETN: state_q <= S_ARD;
							FN_PICK, FN_WAKE, FN_KILL: state_q <= S_TDIV;
							default: begin
								status_q <= RS_NONE;
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_TDIV: if (dv_done) begin
					tick_q <= dv_q;
					state_q <= S_MRD;
				end
				S_MRD: begin
					// min scan: read one slot per cycle
					if (!last_idx && !min_stop_q) begin
						idx_q <= idx_q + 1'b1;
						rd_ok_q <= 1'b1;
						rd_idx_q <= idx_q[AW-1:0];
					end
					state_q <= S_MIN;
				end
				S_MIN: begin
					if (rd_ok_q && r_status == ST_RUNNABLE && !min_stop_q) begin
						total_q <= total_q + 25'(nice_weight(r_nice));
						if (r_vrun == 32'd0 && r_wraps == 32'd0) begin
							min_stop_q <= 1'b1;
							min_ok_q <= 1'b1;
							min_idx_q <= rd_idx_q;
							min_v_q <= 32'd0;
							min_w_q <= 32'd0;
							min_wt_q <= nice_weight(r_nice);
						end else if (!min_ok_q || r_wraps < min_w_q ||
							(r_wraps == min_w_q && r_vrun < min_v_q)) begin
							min_ok_q <= 1'b1;
							min_idx_q <= rd_idx_q;
							min_v_q <= r_vrun;
							min_w_q <= r_wraps;
							min_wt_q <= nice_weight(r_nice);
						end
					end else if (rd_ok_q && r_status == ST_RUNNABLE) begin
						total_q <= total_q + 25'(nice_weight(r_nice));
					end
					if (!rd_ok_q && (last_idx || min_stop_q) && !(min_stop_q && !last_idx
							&& func_q == FN_PICK)) begin
						idx_q <= '0;
						state_q <= S_ARD;
					end else if (!last_idx) begin
						idx_q <= idx_q + 1'b1;
						rd_ok_q <= 1'b1;
						rd_idx_q <= idx_q[AW-1:0];
					end
				end
				S_ARD: begin
					if (func_q == FN_PICK && !min_ok_q) begin
						status_q <= RS_NONE;
						state_q <= S_OUT;
					end else begin
						idx_q <= idx_q + 1'b1;
						rd_ok_q <= 1'b1;
						rd_idx_q <= idx_q[AW-1:0];
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (rd_ok_q && !found_q) begin
						case (func_q)
							FN_PICK: if (rd_idx_q == min_idx_q)
								chosen_q <= 6'(rd_idx_q);
							FN_WAKE: if (r_status == ST_SLEEPING && r_chan == chan_q)
								woken_q <= woken_q + 1'b1;
							FN_KILL, FN_SETN, FN_GETN: if (r_id == id_q) begin
								found_q <= 1'b1;
								chosen_q <= 6'(rd_idx_q);
								if (func_q == FN_GETN) nread_q <= r_nice;
								if (func_q == FN_KILL && r_status == ST_SLEEPING)
									woken_q <= 7'd1;
							end
							default: ;
						endcase
					end
					if (rd_ok_q) begin
						if (!last_idx) begin
							idx_q <= idx_q + 1'b1;
							rd_ok_q <= 1'b1;
							rd_idx_q <= idx_q[AW-1:0];
						end
					end else begin
						if (func_q == FN_PICK) state_q <= S_SDIV;
						else begin
							if ((func_q == FN_KILL || func_q == FN_SETN ||
								func_q == FN_GETN) && !found_q) status_q <= RS_NONE;
							state_q <= S_OUT;
						end
					end
				end
				S_SDIV: if (dv_done) begin
					slice_q <= dv_q[13:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					out_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
